[hw/rtl/tgr_pkg.sv]
// Shared types, codes and defaults for the tile id resolver.
package tgr_pkg;

    localparam int TILESETS_DEF  = 4;
    localparam int ANIMS_DEF     = 16;
    localparam int FRAMES_DEF    = 16;
    localparam int MAP_TILES_DEF = 1024;

    localparam logic [32:0] MAX33 = 33'h1_FFFF_FFFF;
    localparam logic [19:0] TOTAL_MAX = 20'hF_FFFF;

    typedef enum logic [1:0] {
        OP_DESC  = 2'd0,
        OP_FRAME = 2'd1,
        OP_MAP   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    localparam logic [2:0] DSEL_FIRST   = 3'd0;
    localparam logic [2:0] DSEL_COLUMNS = 3'd1;
    localparam logic [2:0] DSEL_TILE_W  = 3'd2;
    localparam logic [2:0] DSEL_TILE_H  = 3'd3;
    localparam logic [2:0] DSEL_SPACING = 3'd4;
    localparam logic [2:0] DSEL_MARGIN  = 3'd5;
    localparam logic [2:0] DSEL_COUNT   = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  tileset_slot;
        logic [2:0]  desc_select;
        logic [9:0]  entry_index;
        logic [3:0]  anim_slot;
        logic        anim_present;
        logic [23:0] load_value;
        logic [15:0] frame_duration;
        logic [23:0] gid;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  match_slot;
        logic [23:0] local_tile;
        logic        animated;
        logic [3:0]  anim_hit;
        logic [23:0] shown_tile;
        logic        rect_valid;
        logic [32:0] src_x;
        logic [32:0] src_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
    } out_item_t;

    typedef struct packed {
        op_t      op;
        in_item_t item;
    } q_item_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_LOCAL,
        B_MAP,
        B_MOD,
        B_WADDR,
        B_WCHK,
        B_RECT,
        B_DIV,
        B_MUL,
        B_SUM,
        B_EMIT
    } bstate_t;

endpackage

[hw/rtl/tgr_if.sv]
// Valid/ready channel interfaces for input items and results.
interface tgr_in_if;
    logic               valid;
    logic               ready;
    tgr_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tgr_out_if;
    logic               valid;
    logic               ready;
    tgr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/tile_gid_animation_uv_resolver.sv]
// A load takes effect once the back end is idle and pops it from the queue; a query
// result is presented directly for the empty tile (gid 0), otherwise after these steps:
// pop, a scan of the TILESETS slots, the local id, then as the tile needs them the map
// lookup, the time modulo, a walk of the frames, the column division, multiply and sum, then emit.
// The back end takes one item at a time; a 2-entry queue takes items meanwhile.
// Reset: tables cleared at once, then a map clearing pass over all TILESETS*MAP_TILES
// entries (4096 by default) during which no item transfer is taken.
module tile_gid_animation_uv_resolver #(
    parameter int TILESETS  = tgr_pkg::TILESETS_DEF,
    parameter int ANIMS     = tgr_pkg::ANIMS_DEF,
    parameter int FRAMES    = tgr_pkg::FRAMES_DEF,
    parameter int MAP_TILES = tgr_pkg::MAP_TILES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tgr_in_if.sink    req,
    tgr_out_if.source rsp
);
    logic             clear_done;
    logic             q_valid;
    logic             q_ready;
    tgr_pkg::q_item_t q_data;

    tgr_front #(
        .TILESETS  (TILESETS),
        .ANIMS     (ANIMS),
        .FRAMES    (FRAMES),
        .MAP_TILES (MAP_TILES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (clear_done),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    tgr_back #(
        .TILESETS  (TILESETS),
        .ANIMS     (ANIMS),
        .FRAMES    (FRAMES),
        .MAP_TILES (MAP_TILES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .rsp        (rsp)
    );
endmodule

[hw/rtl/tgr_ram.sv]
// Generic single write port RAM with registered read.
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/tgr_div.sv]
// Restoring divider, one quotient bit per cycle.
module tgr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [19:0] remainder
);
    logic [31:0] quo_reg, quo_next;
    logic [20:0] rem_reg, rem_next;
    logic [19:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [20:0] shifted;

    always_comb
    begin
        shifted = {rem_reg[19:0], quo_reg[31]};
        if (shifted >= {1'b0, dvs_reg})
        begin
            rem_next = shifted - {1'b0, dvs_reg};
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = shifted;
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[19:0];
endmodule

[hw/rtl/tgr_front.sv]
// Front end: accepts items, drops writes that do nothing, queues the rest.
module tgr_front #(
    parameter int TILESETS  = tgr_pkg::TILESETS_DEF,
    parameter int ANIMS     = tgr_pkg::ANIMS_DEF,
    parameter int FRAMES    = tgr_pkg::FRAMES_DEF,
    parameter int MAP_TILES = tgr_pkg::MAP_TILES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    tgr_in_if.sink            req,
    output logic              q_valid,
    input  logic              q_ready,
    output tgr_pkg::q_item_t  q_data
);
    tgr_pkg::q_item_t ent_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;
    tgr_pkg::op_t     op_c;
    logic             keep_c;
    logic             push;
    logic             pop;

    always_comb
    begin
        op_c = tgr_pkg::op_t'(req.data.cmd);
        case (op_c)
            tgr_pkg::OP_DESC:
                keep_c = (32'(req.data.tileset_slot) < TILESETS) &&
                         (req.data.desc_select <= tgr_pkg::DSEL_COUNT);
            tgr_pkg::OP_FRAME:
                keep_c = (32'(req.data.anim_slot) < ANIMS) &&
                         (32'(req.data.entry_index) < FRAMES);
            tgr_pkg::OP_MAP:
                keep_c = (32'(req.data.tileset_slot) < TILESETS) &&
                         (32'(req.data.entry_index) < MAP_TILES);
            tgr_pkg::OP_QUERY:
                keep_c = 1'b1;
            default:
                keep_c = 1'b0;
        endcase
    end

    assign req.ready = enable && (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready && keep_c;
    assign pop       = q_valid && q_ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = ent_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= '{op: op_c, item: req.data};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !req.ready) else $error("transfer into full queue");
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !enable |-> !req.ready) else $error("transfer during map clear");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("queue pointers disagree with count");
endmodule

[hw/rtl/tgr_back.sv]
// Back end: applies loads and resolves queries through a sequencer.
module tgr_back #(
    parameter int TILESETS  = tgr_pkg::TILESETS_DEF,
    parameter int ANIMS     = tgr_pkg::ANIMS_DEF,
    parameter int FRAMES    = tgr_pkg::FRAMES_DEF,
    parameter int MAP_TILES = tgr_pkg::MAP_TILES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              clear_done,
    input  logic              q_valid,
    output logic              q_ready,
    input  tgr_pkg::q_item_t  q_data,
    tgr_out_if.source         rsp
);
    localparam int SW        = TILESETS > 1 ? $clog2(TILESETS) : 1;
    localparam int AIW       = ANIMS > 1 ? $clog2(ANIMS) : 1;
    localparam int FIW       = FRAMES > 1 ? $clog2(FRAMES) : 1;
    localparam int CW        = $clog2(FRAMES + 1);
    localparam int ACW       = 16 + CW;
    localparam int MAP_DEPTH = TILESETS * MAP_TILES;
    localparam int MAW       = MAP_DEPTH > 1 ? $clog2(MAP_DEPTH) : 1;
    localparam int FR_DEPTH  = ANIMS * FRAMES;
    localparam int FAW       = FR_DEPTH > 1 ? $clog2(FR_DEPTH) : 1;

    tgr_pkg::bstate_t state_reg, state_next;

    logic             set_active_reg [TILESETS];
    logic [23:0]      first_reg [TILESETS];
    logic [15:0]      cols_reg [TILESETS];
    logic [15:0]      tw_reg [TILESETS];
    logic [15:0]      th_reg [TILESETS];
    logic [15:0]      sp_reg [TILESETS];
    logic [15:0]      mg_reg [TILESETS];
    logic [15:0]      tc_reg [TILESETS];
    logic [CW-1:0]    fcnt_reg [ANIMS];
    logic [19:0]      tot_reg [ANIMS];

    logic [MAW-1:0]   clr_reg;
    logic [23:0]      gid_reg;
    logic [31:0]      time_reg;
    logic [SW-1:0]    scan_reg;
    logic             found_reg;
    logic [SW-1:0]    best_reg;
    logic [23:0]      best_id_reg;
    logic [AIW-1:0]   a_reg;
    logic [23:0]      shown_reg;
    logic [19:0]      elapsed_reg;
    logic [ACW-1:0]   acc_reg;
    logic [FIW-1:0]   f_reg;
    logic [FIW-1:0]   nlast_reg;
    logic [15:0]      col_reg;
    logic [23:0]      row_reg;
    logic [32:0]      px_reg;
    logic [40:0]      py_reg;
    tgr_pkg::out_item_t res_reg;
    tgr_pkg::out_item_t out_reg;
    logic             ov_reg;

    tgr_pkg::in_item_t it;
    logic             pop;
    logic             frame_ok;
    logic [AIW-1:0]   wa_c;
    logic [23:0]      local_c;
    logic             lookup_c;
    logic [4:0]       entry_c;
    logic [AIW-1:0]   ea_c;
    logic             anim_c;
    logic [ACW-1:0]   acc_c;
    logic             take_c;
    logic             emit_c;
    logic [33:0]      x_c;
    logic [41:0]      y_c;
    logic [20:0]      tsum_c;

    logic             map_we;
    logic [MAW-1:0]   map_waddr, map_raddr;
    logic [4:0]       map_wdata, map_rdata;
    logic             fr_we;
    logic [FAW-1:0]   fr_waddr, fr_raddr;
    logic [39:0]      fr_rdata;

    logic             div_start, div_done;
    logic [31:0]      div_a, div_q;
    logic [19:0]      div_b, div_r;

    assign it       = q_data.item;
    assign pop      = q_valid && q_ready;
    assign wa_c     = AIW'(it.anim_slot);
    assign frame_ok = (it.entry_index == 10'd0) ||
                      (32'(it.entry_index) == 32'(fcnt_reg[wa_c]));
    assign local_c  = gid_reg - best_id_reg;
    assign lookup_c = (local_c < 24'(tc_reg[best_reg])) && (32'(local_c) < MAP_TILES);
    assign entry_c  = map_rdata;
    assign ea_c     = AIW'(entry_c[3:0]);
    assign anim_c   = entry_c[4] && (32'(entry_c[3:0]) < ANIMS);
    assign acc_c    = acc_reg + ACW'(fr_rdata[15:0]);
    assign take_c   = (ACW'(elapsed_reg) < acc_c) || (f_reg == nlast_reg);
    assign emit_c   = !ov_reg || rsp.ready;
    assign x_c      = 34'(mg_reg[best_reg]) + 34'(px_reg);
    assign y_c      = 42'(mg_reg[best_reg]) + 42'(py_reg);
    assign tsum_c   = 21'(tot_reg[wa_c]) + 21'(it.frame_duration);
    assign clear_done = (state_reg != tgr_pkg::B_CLEAR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tgr_pkg::B_CLEAR:
                if (32'(clr_reg) == MAP_DEPTH - 1)
                begin
                    state_next = tgr_pkg::B_IDLE;
                end
            tgr_pkg::B_IDLE:
                if (q_valid && q_data.op == tgr_pkg::OP_QUERY)
                begin
                    state_next = (it.gid == 24'd0) ? tgr_pkg::B_EMIT : tgr_pkg::B_SCAN;
                end
            tgr_pkg::B_SCAN:
                if (32'(scan_reg) == TILESETS - 1)
                begin
                    state_next = tgr_pkg::B_LOCAL;
                end
            tgr_pkg::B_LOCAL:
                if (!found_reg)
                begin
                    state_next = tgr_pkg::B_EMIT;
                end
                else
                begin
                    state_next = lookup_c ? tgr_pkg::B_MAP : tgr_pkg::B_RECT;
                end
            tgr_pkg::B_MAP:
                if (!anim_c || fcnt_reg[ea_c] == '0)
                begin
                    state_next = tgr_pkg::B_RECT;
                end
                else if (tot_reg[ea_c] == 20'd0)
                begin
                    state_next = tgr_pkg::B_WADDR;
                end
                else
                begin
                    state_next = tgr_pkg::B_MOD;
                end
            tgr_pkg::B_MOD:
                if (div_done)
                begin
                    state_next = tgr_pkg::B_WADDR;
                end
            tgr_pkg::B_WADDR:
                state_next = tgr_pkg::B_WCHK;
            tgr_pkg::B_WCHK:
                state_next = take_c ? tgr_pkg::B_RECT : tgr_pkg::B_WADDR;
            tgr_pkg::B_RECT:
                state_next = (cols_reg[best_reg] == 16'd0) ? tgr_pkg::B_EMIT : tgr_pkg::B_DIV;
            tgr_pkg::B_DIV:
                if (div_done)
                begin
                    state_next = tgr_pkg::B_MUL;
                end
            tgr_pkg::B_MUL:
                state_next = tgr_pkg::B_SUM;
            tgr_pkg::B_SUM:
                state_next = tgr_pkg::B_EMIT;
            tgr_pkg::B_EMIT:
                if (emit_c)
                begin
                    state_next = tgr_pkg::B_IDLE;
                end
            default:
                state_next = tgr_pkg::B_IDLE;
        endcase
    end

    // outputs toward queue, memories and divider
    always_comb
    begin
        q_ready   = (state_reg == tgr_pkg::B_IDLE);
        map_we    = 1'b0;
        map_waddr = MAW'(MAW'(it.tileset_slot) * MAW'(MAP_TILES)) + MAW'(it.entry_index);
        map_wdata = {it.anim_present, it.anim_slot};
        fr_we     = pop && q_data.op == tgr_pkg::OP_FRAME && frame_ok;
        div_start = 1'b0;
        div_a     = 32'(shown_reg);
        div_b     = 20'(cols_reg[best_reg]);
        case (state_reg)
            tgr_pkg::B_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
            end
            tgr_pkg::B_IDLE:
                map_we = pop && q_data.op == tgr_pkg::OP_MAP;
            tgr_pkg::B_MAP:
            begin
                div_start = anim_c && fcnt_reg[ea_c] != '0 && tot_reg[ea_c] != 20'd0;
                div_a     = time_reg;
                div_b     = tot_reg[ea_c];
            end
            tgr_pkg::B_RECT:
                div_start = (cols_reg[best_reg] != 16'd0);
            default:
                div_start = 1'b0;
        endcase
    end

    assign map_raddr = MAW'(MAW'(best_reg) * MAW'(MAP_TILES)) + MAW'(local_c);
    assign fr_waddr  = FAW'(FAW'(wa_c) * FAW'(FRAMES)) + FAW'(it.entry_index);
    assign fr_raddr  = FAW'(FAW'(a_reg) * FAW'(FRAMES)) + FAW'(f_reg);

    tgr_ram #(.WIDTH(5), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    tgr_ram #(.WIDTH(40), .DEPTH(FR_DEPTH)) u_frames (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata ({it.load_value, it.frame_duration}),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    tgr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // control state and stored tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgr_pkg::B_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < TILESETS; i++)
            begin
                set_active_reg[i] <= 1'b0;
                first_reg[i] <= '0;
                cols_reg[i]  <= '0;
                tw_reg[i]    <= '0;
                th_reg[i]    <= '0;
                sp_reg[i]    <= '0;
                mg_reg[i]    <= '0;
                tc_reg[i]    <= '0;
            end
            for (int i = 0; i < ANIMS; i++)
            begin
                fcnt_reg[i] <= '0;
                tot_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tgr_pkg::B_CLEAR)
            begin
                clr_reg <= clr_reg + MAW'(1);
            end
            if (state_reg == tgr_pkg::B_EMIT && emit_c)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (pop && q_data.op == tgr_pkg::OP_DESC)
            begin
                case (it.desc_select)
                    tgr_pkg::DSEL_FIRST:
                    begin
                        first_reg[SW'(it.tileset_slot)]      <= it.load_value;
                        set_active_reg[SW'(it.tileset_slot)] <= 1'b1;
                    end
                    tgr_pkg::DSEL_COLUMNS: cols_reg[SW'(it.tileset_slot)] <= it.load_value[15:0];
                    tgr_pkg::DSEL_TILE_W:  tw_reg[SW'(it.tileset_slot)] <= it.load_value[15:0];
                    tgr_pkg::DSEL_TILE_H:  th_reg[SW'(it.tileset_slot)] <= it.load_value[15:0];
                    tgr_pkg::DSEL_SPACING: sp_reg[SW'(it.tileset_slot)] <= it.load_value[15:0];
                    tgr_pkg::DSEL_MARGIN:  mg_reg[SW'(it.tileset_slot)] <= it.load_value[15:0];
                    tgr_pkg::DSEL_COUNT:   tc_reg[SW'(it.tileset_slot)] <= it.load_value[15:0];
                    default: ;
                endcase
            end
            if (fr_we)
            begin
                fcnt_reg[wa_c] <= CW'(it.entry_index) + CW'(1);
                if (it.entry_index == 10'd0)
                begin
                    tot_reg[wa_c] <= 20'(it.frame_duration);
                end
                else
                begin
                    tot_reg[wa_c] <= tsum_c[20] ? tgr_pkg::TOTAL_MAX : tsum_c[19:0];
                end
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tgr_pkg::B_IDLE:
            begin
                gid_reg     <= it.gid;
                time_reg    <= it.time_ms;
                scan_reg    <= '0;
                found_reg   <= 1'b0;
                best_reg    <= '0;
                best_id_reg <= '0;
                res_reg     <= '0;
            end
            tgr_pkg::B_SCAN:
            begin
                // later slot wins on equal first id
                if (set_active_reg[scan_reg] && first_reg[scan_reg] <= gid_reg &&
                    first_reg[scan_reg] >= best_id_reg)
                begin
                    found_reg   <= 1'b1;
                    best_reg    <= scan_reg;
                    best_id_reg <= first_reg[scan_reg];
                end
                scan_reg <= scan_reg + SW'(1);
            end
            tgr_pkg::B_LOCAL:
            begin
                shown_reg <= local_c;
                if (found_reg)
                begin
                    res_reg.found      <= 1'b1;
                    res_reg.match_slot <= 2'(best_reg);
                    res_reg.local_tile <= local_c;
                    res_reg.shown_tile <= local_c;
                end
            end
            tgr_pkg::B_MAP:
            begin
                a_reg   <= ea_c;
                f_reg   <= '0;
                acc_reg <= '0;
                // zero total: stop on frame 0
                nlast_reg <= (tot_reg[ea_c] == 20'd0) ? '0 : FIW'(fcnt_reg[ea_c] - CW'(1));
                if (anim_c)
                begin
                    res_reg.animated <= 1'b1;
                    res_reg.anim_hit <= entry_c[3:0];
                end
            end
            tgr_pkg::B_MOD:
                elapsed_reg <= div_r;
            tgr_pkg::B_WCHK:
            begin
                acc_reg <= acc_c;
                f_reg   <= f_reg + FIW'(1);
                if (take_c)
                begin
                    shown_reg <= fr_rdata[39:16];
                end
            end
            tgr_pkg::B_RECT:
                res_reg.shown_tile <= shown_reg;
            tgr_pkg::B_DIV:
            begin
                col_reg <= div_r[15:0];
                row_reg <= div_q[23:0];
            end
            tgr_pkg::B_MUL:
            begin
                px_reg <= 33'(col_reg) *
                          33'(17'(tw_reg[best_reg]) + 17'(sp_reg[best_reg]));
                py_reg <= 41'(row_reg) *
                          41'(17'(th_reg[best_reg]) + 17'(sp_reg[best_reg]));
            end
            tgr_pkg::B_SUM:
            begin
                res_reg.rect_valid <= 1'b1;
                res_reg.src_x <= (x_c > 34'(tgr_pkg::MAX33)) ? tgr_pkg::MAX33 : x_c[32:0];
                res_reg.src_y <= (y_c > 42'(tgr_pkg::MAX33)) ? tgr_pkg::MAX33 : y_c[32:0];
                res_reg.rect_w <= tw_reg[best_reg];
                res_reg.rect_h <= th_reg[best_reg];
            end
            tgr_pkg::B_EMIT:
                if (emit_c)
                begin
                    out_reg <= res_reg;
                end
            default: ;
        endcase
    end

    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tgr_pkg::B_CLEAR |-> !q_ready) else $error("pop during map clear");
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tgr_pkg::B_EMIT && emit_c) |=> ov_reg)
        else $error("result not presented");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_start) else $error("divider restarted");
    a_local_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tgr_pkg::B_LOCAL && found_reg) |-> best_id_reg <= gid_reg)
        else $error("matched first id above tile id");
endmodule
